@@ hdl/ssp_pkg.sv @@
// ssp_pkg: shared types and constants of the swap shuffle permutation block.
// Used by ssp_ctrl, ssp_dp and the top level; depends on nothing.
package ssp_pkg;

    localparam int VALUE_W = 9;
    localparam int SIZE_W  = 9;
    localparam int RAND_W  = 15;
    localparam int POS_W   = 8;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int MCNT_W  = $clog2(RAND_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [MCNT_W-1:0] MCNT_LAST  = MCNT_W'(RAND_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_RESTART = 2'd0,
        MODE_SHUFFLE = 2'd1,
        MODE_READ    = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOR  = 2'd1,
        ST_LATE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        A_CNT  = 2'd0,
        A_STEP = 2'd1,
        A_IDX  = 2'd2,
        A_POS  = 2'd3
    } t_addr_sel;

    typedef enum logic [1:0] {
        W_INIT  = 2'd0,
        W_RDATA = 2'd1,
        W_TA    = 2'd2
    } t_wdata_sel;

    typedef struct packed {
        logic       take;
        logic       clr_step;
        logic       init_step;
        logic       mod_start;
        logic       mod_step;
        logic       we;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       latch_ta;
        logic       cap_value;
        logic       set_status;
        t_status    status_code;
        logic       step_inc;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  shuf_done;
        logic  pos_oor;
        logic  init_last;
        logic  mod_last;
    } t_stat;

endpackage

@@ hdl/ssp_ram.sv @@
// ssp_ram: generic single-port RAM with registered read data.
// Standalone; no package dependency.
module ssp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ssp_ctrl.sv @@
// ssp_ctrl: sequencer of the swap shuffle permutation block.
// Drives ssp_dp through ssp_pkg::t_cmd and reads ssp_pkg::t_stat.
module ssp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  ssp_pkg::t_stat i_st,
    output ssp_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_INIT = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_DEC  = 12'b000000000100,
        S_RST  = 12'b000000001000,
        S_MOD  = 12'b000000010000,
        S_RD1  = 12'b000000100000,
        S_RD2  = 12'b000001000000,
        S_WR1  = 12'b000010000000,
        S_WR2  = 12'b000100000000,
        S_RDP  = 12'b001000000000,
        S_RDV  = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_o_valid;
    logic          n_o_valid;
    ssp_pkg::t_cmd cmd;

    always_comb begin
        n_state          = r_state;
        cmd              = '0;
        cmd.addr_sel     = ssp_pkg::A_CNT;
        cmd.wdata_sel    = ssp_pkg::W_INIT;
        cmd.status_code  = ssp_pkg::ST_OK;
        case (r_state)
            S_INIT, S_RST: begin
                cmd.we        = 1'b1;
                cmd.init_step = 1'b1;
                if (i_st.init_last) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_FIN;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.take = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                case (i_st.mode)
                    ssp_pkg::MODE_RESTART: begin
                        cmd.clr_step = 1'b1;
                        n_state      = S_RST;
                    end
                    ssp_pkg::MODE_SHUFFLE: begin
                        if (i_st.shuf_done) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ssp_pkg::ST_LATE;
                            n_state         = S_FIN;
                        end else begin
                            cmd.mod_start = 1'b1;
                            n_state       = S_MOD;
                        end
                    end
                    ssp_pkg::MODE_READ: begin
                        if (i_st.pos_oor) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ssp_pkg::ST_OOR;
                            n_state         = S_FIN;
                        end else begin
                            n_state = S_RDP;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_st.mod_last) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                cmd.addr_sel = ssp_pkg::A_STEP;
                n_state      = S_RD2;
            end
            S_RD2: begin
                cmd.addr_sel = ssp_pkg::A_IDX;
                cmd.latch_ta = 1'b1;
                n_state      = S_WR1;
            end
            S_WR1: begin
                cmd.we        = 1'b1;
                cmd.addr_sel  = ssp_pkg::A_STEP;
                cmd.wdata_sel = ssp_pkg::W_RDATA;
                n_state       = S_WR2;
            end
            S_WR2: begin
                cmd.we        = 1'b1;
                cmd.addr_sel  = ssp_pkg::A_IDX;
                cmd.wdata_sel = ssp_pkg::W_TA;
                cmd.step_inc  = 1'b1;
                n_state       = S_FIN;
            end
            S_RDP: begin
                cmd.addr_sel = ssp_pkg::A_POS;
                n_state      = S_RDV;
            end
            S_RDV: begin
                cmd.cap_value = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (cmd.load_out) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_cmd   = cmd;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_DEC))
        else $error("accepted word not decoded");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !cmd.we)
        else $error("store written while idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_o_valid || i_ready))
        else $error("result overwrites a pending word");
`endif

endmodule

@@ hdl/ssp_dp.sv @@
// ssp_dp: datapath of the swap shuffle permutation block: size register, step
// counter, bit-serial remainder unit, permutation store and result registers.
// Depends on ssp_pkg and ssp_ram.
module ssp_dp #(
    parameter int MAX_SIZE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ssp_pkg::MODE_W-1:0]    i_mode,
    input  logic [ssp_pkg::RAND_W-1:0]    i_rand_word,
    input  logic [ssp_pkg::POS_W-1:0]     i_position,
    input  logic                          i_cfg_we,
    input  logic [ssp_pkg::SIZE_W-1:0]    i_cfg_data,
    input  ssp_pkg::t_cmd                 i_cmd,
    output ssp_pkg::t_stat                o_st,
    output logic [ssp_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_done_res,
    output logic [ssp_pkg::STAT_W-1:0]    o_status
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int CW = (NW > ssp_pkg::SIZE_W) ? NW : ssp_pkg::SIZE_W;
    localparam int RW = AW + 1;

    logic [ssp_pkg::SIZE_W-1:0]  r_size;
    logic [NW-1:0]               r_step;
    logic [AW-1:0]               r_cnt;
    logic [AW-1:0]               r_rem;
    logic [ssp_pkg::RAND_W-1:0]  r_q;
    logic [ssp_pkg::MCNT_W-1:0]  r_mcnt;
    ssp_pkg::t_mode              r_mode;
    logic [ssp_pkg::POS_W-1:0]   r_pos;
    logic [ssp_pkg::VALUE_W-1:0] r_ta;
    logic [ssp_pkg::VALUE_W-1:0] r_value;
    ssp_pkg::t_status            r_status;
    logic [ssp_pkg::VALUE_W-1:0] r_o_value;
    logic                        r_o_done;
    ssp_pkg::t_status            r_o_status;

    logic [CW-1:0]               size_ext;
    logic [CW-1:0]               n_c;
    logic [NW-1:0]               n_eff;
    logic                        shuf_done;
    logic [CW-1:0]               pos_ext;
    logic [CW-1:0]               init_val;
    logic [RW-1:0]               rem2;
    logic [RW-1:0]               n_r;
    logic [RW-1:0]               rem_diff;
    logic [AW-1:0]               n_rem;
    logic [AW-1:0]               addr;
    logic [ssp_pkg::VALUE_W-1:0] wdata;
    logic [ssp_pkg::VALUE_W-1:0] rdata;
    logic                        init_last;

    always_comb begin
        size_ext = CW'(r_size);
        if (size_ext == '0) begin
            n_c = CW'(1);
        end else if (size_ext > CW'(MAX_SIZE)) begin
            n_c = CW'(MAX_SIZE);
        end else begin
            n_c = size_ext;
        end
    end

    assign n_eff     = n_c[NW-1:0];
    assign shuf_done = (r_step >= n_eff);
    assign pos_ext   = CW'(r_pos);
    assign init_val  = CW'(r_cnt) + CW'(1);
    assign init_last = (r_cnt == AW'(MAX_SIZE - 1));

    assign rem2     = {r_rem, r_q[ssp_pkg::RAND_W-1]};
    assign n_r      = RW'(n_eff);
    assign rem_diff = (rem2 >= n_r) ? (rem2 - n_r) : rem2;
    assign n_rem    = rem_diff[AW-1:0];

    always_comb begin
        case (i_cmd.addr_sel)
            ssp_pkg::A_CNT:  addr = r_cnt;
            ssp_pkg::A_STEP: addr = r_step[AW-1:0];
            ssp_pkg::A_IDX:  addr = r_rem;
            ssp_pkg::A_POS:  addr = pos_ext[AW-1:0];
            default:         addr = r_cnt;
        endcase
        case (i_cmd.wdata_sel)
            ssp_pkg::W_INIT:  wdata = init_val[ssp_pkg::VALUE_W-1:0];
            ssp_pkg::W_RDATA: wdata = rdata;
            ssp_pkg::W_TA:    wdata = r_ta;
            default:          wdata = rdata;
        endcase
    end

    ssp_ram #(
        .WIDTH (ssp_pkg::VALUE_W),
        .DEPTH (MAX_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= ssp_pkg::SIZE_RESET;
            r_step <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + NW'(1);
            end
            if (i_cmd.init_step) begin
                r_cnt <= init_last ? '0 : r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode   <= ssp_pkg::t_mode'(i_mode);
            r_q      <= i_rand_word;
            r_pos    <= i_position;
            r_value  <= '0;
            r_status <= ssp_pkg::ST_OK;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.cap_value) begin
                r_value <= rdata;
            end
            if (i_cmd.mod_step) begin
                r_q <= {r_q[ssp_pkg::RAND_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mod_start) begin
            r_rem  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= n_rem;
            r_mcnt <= r_mcnt + ssp_pkg::MCNT_W'(1);
        end
        if (i_cmd.latch_ta) begin
            r_ta <= rdata;
        end
        if (i_cmd.load_out) begin
            r_o_value  <= r_value;
            r_o_done   <= shuf_done;
            r_o_status <= r_status;
        end
    end

    assign o_st.mode      = r_mode;
    assign o_st.shuf_done = shuf_done;
    assign o_st.pos_oor   = (pos_ext >= n_c);
    assign o_st.init_last = init_last;
    assign o_st.mod_last  = (r_mcnt == ssp_pkg::MCNT_LAST);

    assign o_value    = r_o_value;
    assign o_done_res = r_o_done;
    assign o_status   = r_o_status;

`ifndef SYNTHESIS
    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_inc |-> !shuf_done)
        else $error("step counter advanced past size");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.we && (i_cmd.addr_sel == ssp_pkg::A_IDX)) |-> (RW'(r_rem) < n_r))
        else $error("swap index not reduced below size");
`endif

endmodule

@@ hdl/swap_shuffle_permutation.sv @@
// swap_shuffle_permutation: one word at a time. States from accept to result valid: read
// DEC, RDP, RDV, FIN; rejected read or shuffle, or unused mode DEC, FIN; shuffle DEC, MOD
// (remainder loop), RD1, RD2, WR1, WR2 (two reads, two writes on the single store port),
// FIN; restart DEC, RST (store walk), FIN. Next word can be accepted from the cycle after
// loading of the output register. Reset is synchronous, active low; after it the store
// walk writes index + 1 to each address, ready low; size resets to 256, step counter to 0.
module swap_shuffle_permutation #(
    parameter int MAX_SIZE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ssp_pkg::MODE_W-1:0]  i_mode,
    input  logic [ssp_pkg::RAND_W-1:0]  i_rand_word,
    input  logic [ssp_pkg::POS_W-1:0]   i_position,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ssp_pkg::VALUE_W-1:0] o_value,
    output logic                        o_done_res,
    output logic [ssp_pkg::STAT_W-1:0]  o_status,
    input  logic                        i_cfg_we,
    input  logic [ssp_pkg::SIZE_W-1:0]  i_cfg_data
);

    ssp_pkg::t_cmd  cmd;
    ssp_pkg::t_stat st;

    ssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    ssp_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_rand_word (i_rand_word),
        .i_position  (i_position),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_value     (o_value),
        .o_done_res  (o_done_res),
        .o_status    (o_status)
    );

endmodule
